### rtl/gopm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gopm_pkg
// shared constants, codes and payload types of the guided pair matcher
// ----------------------------------------------------------------------------
package gopm_pkg;

    // table sizes
    localparam int MAX_WORKERS = 1024;
    localparam int MAX_TASKS   = 1024;
    localparam int MAX_BUCKETS = 1024;

    // field widths
    localparam int COUNT_W = 11;
    localparam int IDX_W   = 10;
    localparam int GRID_W  = 11;
    localparam int SLOT_W  = 10;
    localparam int CELL_W  = 10;
    localparam int TOTAL_W = 11;
    localparam int MARK_W  = 2;

    // match total saturates here
    localparam int TOTAL_CAP = 2047;

    // memory address widths
    localparam int WRK_AW = $clog2(MAX_WORKERS);
    localparam int TSK_AW = $clog2(MAX_TASKS);
    localparam int BKT_AW = $clog2(MAX_BUCKETS);

    // clearing pass covers the deepest table
    localparam int WT_DEPTH  = (MAX_WORKERS > MAX_TASKS) ? MAX_WORKERS : MAX_TASKS;
    localparam int CLR_DEPTH = (WT_DEPTH > MAX_BUCKETS) ? WT_DEPTH : MAX_BUCKETS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // bucket arithmetic: slot * grid + cell
    localparam int PROD_W = SLOT_W + GRID_W;
    localparam int BSUM_W = PROD_W + 1;

    // front to back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_LOAD_COUNTS = 2'd0,
        OP_LOAD_PAIR   = 2'd1,
        OP_ARRIVAL     = 2'd2,
        OP_CLEAR       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_BUCKET   = 2'd1,
        STATUS_BAD_POSITION = 2'd2
    } status_t;

    typedef enum logic [MARK_W-1:0] {
        MARK_UNSEEN  = 2'd0,
        MARK_WAITING = 2'd1,
        MARK_MATCHED = 2'd2
    } mark_t;

    typedef struct packed {
        op_t                op;
        logic [IDX_W-1:0]   bucket;
        logic [COUNT_W-1:0] worker_count;
        logic [COUNT_W-1:0] task_count;
        logic [IDX_W-1:0]   guide_worker;
        logic [IDX_W-1:0]   guide_task;
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic [CELL_W-1:0]  cell_req;
    } in_t;

    typedef struct packed {
        logic               accepted;
        logic               matched;
        logic [IDX_W-1:0]   position;
        logic [TOTAL_W-1:0] match_total;
        status_t            status;
    } out_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t                op;
        logic               bad_bucket;
        logic               bad_pair;
        logic [BKT_AW-1:0]  bucket;
        logic [COUNT_W-1:0] worker_count;
        logic [COUNT_W-1:0] task_count;
        logic [IDX_W-1:0]   guide_worker;
        logic [IDX_W-1:0]   guide_task;
        logic               kind;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] worker_end;
        logic [COUNT_W-1:0] worker_next;
        logic [COUNT_W-1:0] task_end;
        logic [COUNT_W-1:0] task_next;
    } bucket_word_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } partner_t;

endpackage
`default_nettype wire

### rtl/gopm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gopm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module gopm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/gopm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gopm_front
// input stage: takes items, works out the bucket and classifies range faults
// ----------------------------------------------------------------------------
module gopm_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire gopm_pkg::in_t                item,
    output logic                              full,
    input  wire logic                         cfg_we,
    input  wire logic [gopm_pkg::GRID_W-1:0]  cfg_data,
    input  wire logic                         clearing,
    input  wire logic                         q_full,
    output logic                              q_push,
    output gopm_pkg::cmd_t                    q_wdata
);

    logic                             f_valid_reg;
    logic                             f_valid_next;
    gopm_pkg::in_t                    f_item_reg;
    logic [gopm_pkg::PROD_W-1:0]      f_prod_reg;
    logic [gopm_pkg::GRID_W-1:0]      grid_reg;
    logic                             accept;
    logic [gopm_pkg::BSUM_W-1:0]      bsum;

    assign full   = clearing || (f_valid_reg && q_full);
    assign accept = push && !full;
    assign q_push = f_valid_reg && !q_full;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            grid_reg    <= gopm_pkg::GRID_W'(1);
        end
        else
        begin
            f_valid_reg <= f_valid_next;
            if (cfg_we)
            begin
                grid_reg <= cfg_data;
            end
        end
    end

    // slot times grid count is registered with the item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_item_reg <= item;
            f_prod_reg <= gopm_pkg::PROD_W'(item.slot) * gopm_pkg::PROD_W'(grid_reg);
        end
    end

    always_comb
    begin
        bsum = gopm_pkg::BSUM_W'(f_prod_reg) + gopm_pkg::BSUM_W'(f_item_reg.cell_req);
        q_wdata.op           = f_item_reg.op;
        q_wdata.worker_count = f_item_reg.worker_count;
        q_wdata.task_count   = f_item_reg.task_count;
        q_wdata.guide_worker = f_item_reg.guide_worker;
        q_wdata.guide_task   = f_item_reg.guide_task;
        q_wdata.kind         = f_item_reg.kind;
        q_wdata.bad_pair     = (f_item_reg.guide_worker >= gopm_pkg::MAX_WORKERS)
                            || (f_item_reg.guide_task >= gopm_pkg::MAX_TASKS);
        if (f_item_reg.op == gopm_pkg::OP_ARRIVAL)
        begin
            q_wdata.bad_bucket = (bsum >= gopm_pkg::MAX_BUCKETS);
            q_wdata.bucket     = bsum[gopm_pkg::BKT_AW-1:0];
        end
        else
        begin
            q_wdata.bad_bucket = (f_item_reg.bucket >= gopm_pkg::MAX_BUCKETS);
            q_wdata.bucket     = f_item_reg.bucket[gopm_pkg::BKT_AW-1:0];
        end
    end

endmodule
`default_nettype wire

### rtl/gopm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gopm_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module gopm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire gopm_pkg::cmd_t  wdata,
    output logic                 full,
    input  wire logic            pop,
    output gopm_pkg::cmd_t       rdata,
    output logic                 empty
);

    gopm_pkg::cmd_t                  data_reg [gopm_pkg::QUEUE_DEPTH];
    logic [gopm_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [gopm_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [gopm_pkg::QPTR_W:0]       count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (count_reg == (gopm_pkg::QPTR_W+1)'(gopm_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

### rtl/gopm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gopm_back
// executes commands against the bucket, partner and mark tables
// ----------------------------------------------------------------------------
module gopm_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  wire gopm_pkg::cmd_t  q_rdata,
    output logic                 q_pop,
    output logic                 clearing,
    output gopm_pkg::out_t       result,
    output logic                 empty,
    input  wire logic            pop
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_BKT   = 5'b00100,
        S_PTR   = 5'b01000,
        S_OTH   = 5'b10000
    } state_t;

    state_t                           state_reg, state_next;
    logic [gopm_pkg::CLR_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [gopm_pkg::COUNT_W-1:0]     run_w_reg, run_w_next;
    logic [gopm_pkg::COUNT_W-1:0]     run_t_reg, run_t_next;
    logic [gopm_pkg::TOTAL_W-1:0]     pair_reg, pair_next;
    gopm_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [gopm_pkg::COUNT_W-1:0]     pos_reg, pos_next;
    logic [gopm_pkg::IDX_W-1:0]       q_reg, q_next;
    gopm_pkg::out_t                   res_reg, res_next;
    logic                             res_valid_reg, res_valid_next;

    // table ports
    logic                             bkt_we;
    logic [gopm_pkg::BKT_AW-1:0]      bkt_waddr, bkt_raddr;
    gopm_pkg::bucket_word_t           bkt_wdata, bkt_rdata;
    logic                             wp_we, tp_we;
    logic [gopm_pkg::WRK_AW-1:0]      wp_waddr, wp_raddr;
    logic [gopm_pkg::TSK_AW-1:0]      tp_waddr, tp_raddr;
    gopm_pkg::partner_t               wp_wdata, wp_rdata, tp_wdata, tp_rdata;
    logic                             wm_we, tm_we;
    logic [gopm_pkg::WRK_AW-1:0]      wm_waddr, wm_raddr;
    logic [gopm_pkg::TSK_AW-1:0]      tm_waddr, tm_raddr;
    logic [gopm_pkg::MARK_W-1:0]      wm_wdata, wm_rdata, tm_wdata, tm_rdata;

    gopm_ram #(.WIDTH($bits(gopm_pkg::bucket_word_t)), .DEPTH(gopm_pkg::MAX_BUCKETS)) u_bkt_ram (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (bkt_raddr),
        .rdata (bkt_rdata)
    );

    gopm_ram #(.WIDTH($bits(gopm_pkg::partner_t)), .DEPTH(gopm_pkg::MAX_WORKERS)) u_wp_ram (
        .clk   (clk),
        .we    (wp_we),
        .waddr (wp_waddr),
        .wdata (wp_wdata),
        .raddr (wp_raddr),
        .rdata (wp_rdata)
    );

    gopm_ram #(.WIDTH($bits(gopm_pkg::partner_t)), .DEPTH(gopm_pkg::MAX_TASKS)) u_tp_ram (
        .clk   (clk),
        .we    (tp_we),
        .waddr (tp_waddr),
        .wdata (tp_wdata),
        .raddr (tp_raddr),
        .rdata (tp_rdata)
    );

    gopm_ram #(.WIDTH(gopm_pkg::MARK_W), .DEPTH(gopm_pkg::MAX_WORKERS)) u_wm_ram (
        .clk   (clk),
        .we    (wm_we),
        .waddr (wm_waddr),
        .wdata (wm_wdata),
        .raddr (wm_raddr),
        .rdata (wm_rdata)
    );

    gopm_ram #(.WIDTH(gopm_pkg::MARK_W), .DEPTH(gopm_pkg::MAX_TASKS)) u_tm_ram (
        .clk   (clk),
        .we    (tm_we),
        .waddr (tm_waddr),
        .wdata (tm_wdata),
        .raddr (tm_raddr),
        .rdata (tm_rdata)
    );

    assign clearing = (state_reg == S_CLEAR);
    assign result   = res_reg;
    assign empty    = !res_valid_reg;

    always_comb
    begin
        logic                           can_start;
        logic [gopm_pkg::COUNT_W:0]     wsum;
        logic [gopm_pkg::COUNT_W:0]     tsum;
        logic [gopm_pkg::COUNT_W-1:0]   wsat;
        logic [gopm_pkg::COUNT_W-1:0]   tsat;
        logic [gopm_pkg::COUNT_W-1:0]   p;
        logic [gopm_pkg::COUNT_W-1:0]   e;
        logic                           p_ok;
        gopm_pkg::partner_t             own_part;
        logic [gopm_pkg::MARK_W-1:0]    own_mark;
        logic [gopm_pkg::MARK_W-1:0]    oth_mark;
        logic                           q_ok;
        logic                           emit;

        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        run_w_next     = run_w_reg;
        run_t_next     = run_t_reg;
        pair_next      = pair_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        q_next         = q_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        q_pop          = 1'b0;
        emit           = 1'b0;

        res_next.accepted = 1'b0;
        res_next.matched  = 1'b0;
        res_next.position = '0;
        res_next.status   = gopm_pkg::STATUS_OK;

        bkt_we    = 1'b0;
        bkt_waddr = cmd_reg.bucket;
        bkt_wdata = bkt_rdata;
        bkt_raddr = q_rdata.bucket;
        wp_we     = 1'b0;
        wp_waddr  = q_rdata.guide_worker[gopm_pkg::WRK_AW-1:0];
        wp_wdata  = '{valid: 1'b1, idx: q_rdata.guide_task};
        wp_raddr  = '0;
        tp_we     = 1'b0;
        tp_waddr  = q_rdata.guide_task[gopm_pkg::TSK_AW-1:0];
        tp_wdata  = '{valid: 1'b1, idx: q_rdata.guide_worker};
        tp_raddr  = '0;
        wm_we     = 1'b0;
        wm_waddr  = '0;
        wm_wdata  = gopm_pkg::MARK_WAITING;
        wm_raddr  = '0;
        tm_we     = 1'b0;
        tm_waddr  = '0;
        tm_wdata  = gopm_pkg::MARK_WAITING;
        tm_raddr  = '0;

        can_start = !q_empty && (!res_valid_reg || pop);
        wsum      = {1'b0, run_w_reg} + {1'b0, q_rdata.worker_count};
        tsum      = {1'b0, run_t_reg} + {1'b0, q_rdata.task_count};
        wsat      = (wsum > gopm_pkg::MAX_WORKERS) ? gopm_pkg::COUNT_W'(gopm_pkg::MAX_WORKERS)
                                                   : wsum[gopm_pkg::COUNT_W-1:0];
        tsat      = (tsum > gopm_pkg::MAX_TASKS) ? gopm_pkg::COUNT_W'(gopm_pkg::MAX_TASKS)
                                                 : tsum[gopm_pkg::COUNT_W-1:0];

        p         = cmd_reg.kind ? bkt_rdata.task_next : bkt_rdata.worker_next;
        e         = cmd_reg.kind ? bkt_rdata.task_end : bkt_rdata.worker_end;
        p_ok      = (p < e) && (cmd_reg.kind ? (p < gopm_pkg::MAX_TASKS)
                                             : (p < gopm_pkg::MAX_WORKERS));
        own_part  = cmd_reg.kind ? tp_rdata : wp_rdata;
        own_mark  = cmd_reg.kind ? tm_rdata : wm_rdata;
        oth_mark  = cmd_reg.kind ? wm_rdata : tm_rdata;
        q_ok      = cmd_reg.kind ? (own_part.idx < gopm_pkg::MAX_WORKERS)
                                 : (own_part.idx < gopm_pkg::MAX_TASKS);

        case (state_reg)
            S_CLEAR:
            begin
                // one entry of every table per cycle
                bkt_we    = (clr_cnt_reg < gopm_pkg::MAX_BUCKETS);
                bkt_waddr = clr_cnt_reg[gopm_pkg::BKT_AW-1:0];
                bkt_wdata = '0;
                wp_we     = (clr_cnt_reg < gopm_pkg::MAX_WORKERS);
                wp_waddr  = clr_cnt_reg[gopm_pkg::WRK_AW-1:0];
                wp_wdata  = '0;
                tp_we     = (clr_cnt_reg < gopm_pkg::MAX_TASKS);
                tp_waddr  = clr_cnt_reg[gopm_pkg::TSK_AW-1:0];
                tp_wdata  = '0;
                wm_we     = wp_we;
                wm_waddr  = clr_cnt_reg[gopm_pkg::WRK_AW-1:0];
                wm_wdata  = gopm_pkg::MARK_UNSEEN;
                tm_we     = tp_we;
                tm_waddr  = clr_cnt_reg[gopm_pkg::TSK_AW-1:0];
                tm_wdata  = gopm_pkg::MARK_UNSEEN;
                if (clr_cnt_reg == gopm_pkg::CLR_W'(gopm_pkg::CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (can_start)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_rdata;
                    case (q_rdata.op)
                        gopm_pkg::OP_LOAD_COUNTS:
                        begin
                            emit = 1'b1;
                            if (q_rdata.bad_bucket)
                            begin
                                res_next.status = gopm_pkg::STATUS_BAD_BUCKET;
                            end
                            else
                            begin
                                bkt_we    = 1'b1;
                                bkt_waddr = q_rdata.bucket;
                                bkt_wdata = '{worker_end: wsat, worker_next: run_w_reg,
                                              task_end: tsat, task_next: run_t_reg};
                                run_w_next = wsat;
                                run_t_next = tsat;
                            end
                        end

                        gopm_pkg::OP_LOAD_PAIR:
                        begin
                            emit = 1'b1;
                            if (q_rdata.bad_pair)
                            begin
                                res_next.status = gopm_pkg::STATUS_BAD_POSITION;
                            end
                            else
                            begin
                                wp_we = 1'b1;
                                tp_we = 1'b1;
                            end
                        end

                        gopm_pkg::OP_ARRIVAL:
                        begin
                            if (q_rdata.bad_bucket)
                            begin
                                emit            = 1'b1;
                                res_next.status = gopm_pkg::STATUS_BAD_BUCKET;
                            end
                            else
                            begin
                                state_next = S_BKT;
                            end
                        end

                        default:
                        begin
                            // clear all: sums reset now, tables swept next
                            emit         = 1'b1;
                            run_w_next   = '0;
                            run_t_next   = '0;
                            pair_next    = '0;
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                    endcase
                end
            end

            S_BKT:
            begin
                if (p_ok)
                begin
                    pos_next  = p;
                    bkt_we    = 1'b1;
                    bkt_waddr = cmd_reg.bucket;
                    if (cmd_reg.kind)
                    begin
                        bkt_wdata.task_next = p + 1'b1;
                    end
                    else
                    begin
                        bkt_wdata.worker_next = p + 1'b1;
                    end
                    wp_raddr   = p[gopm_pkg::WRK_AW-1:0];
                    wm_raddr   = p[gopm_pkg::WRK_AW-1:0];
                    tp_raddr   = p[gopm_pkg::TSK_AW-1:0];
                    tm_raddr   = p[gopm_pkg::TSK_AW-1:0];
                    state_next = S_PTR;
                end
                else
                begin
                    // bucket exhausted
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_PTR:
            begin
                if ((own_mark == gopm_pkg::MARK_UNSEEN) && own_part.valid && q_ok)
                begin
                    q_next     = own_part.idx;
                    wm_raddr   = own_part.idx[gopm_pkg::WRK_AW-1:0];
                    tm_raddr   = own_part.idx[gopm_pkg::TSK_AW-1:0];
                    state_next = S_OTH;
                end
                else
                begin
                    emit              = 1'b1;
                    res_next.accepted = 1'b1;
                    res_next.position = pos_reg[gopm_pkg::IDX_W-1:0];
                    state_next        = S_IDLE;
                    if ((own_mark == gopm_pkg::MARK_UNSEEN) && own_part.valid)
                    begin
                        // partner index beyond the table: wait alone
                        wm_we    = !cmd_reg.kind;
                        tm_we    = cmd_reg.kind;
                        wm_waddr = pos_reg[gopm_pkg::WRK_AW-1:0];
                        tm_waddr = pos_reg[gopm_pkg::TSK_AW-1:0];
                    end
                end
            end

            S_OTH:
            begin
                emit              = 1'b1;
                res_next.accepted = 1'b1;
                res_next.position = pos_reg[gopm_pkg::IDX_W-1:0];
                state_next        = S_IDLE;
                wm_we             = 1'b1;
                tm_we             = 1'b1;
                if (cmd_reg.kind)
                begin
                    tm_waddr = pos_reg[gopm_pkg::TSK_AW-1:0];
                    wm_waddr = q_reg[gopm_pkg::WRK_AW-1:0];
                end
                else
                begin
                    wm_waddr = pos_reg[gopm_pkg::WRK_AW-1:0];
                    tm_waddr = q_reg[gopm_pkg::TSK_AW-1:0];
                end
                if (oth_mark == gopm_pkg::MARK_WAITING)
                begin
                    res_next.matched = 1'b1;
                    wm_wdata         = gopm_pkg::MARK_MATCHED;
                    tm_wdata         = gopm_pkg::MARK_MATCHED;
                    if (pair_reg != gopm_pkg::TOTAL_W'(gopm_pkg::TOTAL_CAP))
                    begin
                        pair_next = pair_reg + 1'b1;
                    end
                end
                else
                begin
                    // only the arriving side goes to waiting
                    wm_we = !cmd_reg.kind;
                    tm_we = cmd_reg.kind;
                end
            end

            default:
            begin
                clr_cnt_next = '0;
                state_next   = S_CLEAR;
            end
        endcase

        res_next.match_total = pair_next;
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            run_w_reg     <= '0;
            run_t_reg     <= '0;
            pair_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            run_w_reg     <= run_w_next;
            run_t_reg     <= run_t_next;
            pair_reg      <= pair_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        pos_reg <= pos_next;
        q_reg   <= q_next;
        res_reg <= res_next;
    end

endmodule
`default_nettype wire

### rtl/guided_online_pair_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// guided_online_pair_matcher: online worker/task matching against a guide
// arrivals step the back end through bucket, partner and partner mark
// reads; loads finish in the idle state; reset and clear start a sweep of
// all 1024 table entries during which full stays high
// ----------------------------------------------------------------------------
module guided_online_pair_matcher (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire gopm_pkg::in_t                item,
    output logic                              full,
    input  wire logic                         pop,
    output gopm_pkg::out_t                    result,
    output logic                              empty,
    input  wire logic                         cfg_we,
    input  wire logic [gopm_pkg::GRID_W-1:0]  cfg_data
);

    // front and back meet through the command queue and the clearing flag
    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_empty;
    gopm_pkg::cmd_t         q_wdata;
    gopm_pkg::cmd_t         q_rdata;
    logic                   clearing;

    // front: registers each transfer with slot times grid count, then
    // adds the cell and flags out-of-range buckets and guide positions
    gopm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // four-entry queue so the front keeps taking transfers while the
    // back works through the dependent table reads of an arrival
    gopm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // back: owns the tables and the result register; full is held high
    // by the front while the back sweeps the tables
    gopm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .clearing (clearing),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule
`default_nettype wire
